>>> sv/bso_pkg.sv
`timescale 1ns / 1ps
package bso_pkg;

   localparam int CAPACITY  = 64;
   localparam int DATA_W    = 32;
   localparam int MODE_W    = 2;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int DIV_CNT_W = $clog2(DATA_W);

   localparam logic [MODE_W-1:0] MODE_ASCEND  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DESCEND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMAIN  = 2'd2;

   typedef enum logic [3:0] {
      S_LOAD,
      S_PASS_START,
      S_PASS_CARRY,
      S_READ,
      S_LATCH,
      S_DIV,
      S_STEP,
      S_PASS_END,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_WAIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CARRY,
      OP_LATCH_B,
      OP_STEP,
      OP_PASS_END,
      OP_EMIT_LOAD,
      OP_EMIT_NEXT
   } op_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_ZERO,
      RD_NEXT,
      RD_EMIT
   } rd_sel_type;

   typedef struct packed {
      op_type     op;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic n_gt1;       // more than one element held
      logic pair_more;   // another pair follows the current one
      logic pass_last;   // current pass is the final one
      logic div_busy;
      logic emit_last;   // current emit index is the final element
      logic rsp_taken;
   } status_type;

endpackage

>>> sv/bso_if.sv
`timescale 1ns / 1ps
interface bso_req_if;
   import bso_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     last_in;
   modport source (output valid, value, last_in, input ready);
   modport sink   (input valid, value, last_in, output ready);
endinterface

interface bso_rsp_if;
   import bso_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sorted_value;
   logic                     last_out;
   logic                     overflowed;
   modport source (output valid, sorted_value, last_out, overflowed, input ready);
   modport sink   (input valid, sorted_value, last_out, overflowed, output ready);
endinterface

interface bso_csr_if;
   import bso_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> sv/bso_div.sv
`timescale 1ns / 1ps
// Restoring remainder unit, one quotient bit per cycle.
module bso_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bso_pkg::DATA_W-1:0]  dividend,
   input  logic [bso_pkg::DATA_W-1:0]  divisor,
   output logic                        busy,
   output logic [bso_pkg::DATA_W-1:0]  remainder
);
   import bso_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    dvs_ff, dvs_in;
   logic [DATA_W:0]      trial;
   logic [DATA_W:0]      diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DATA_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DATA_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         rem_in = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

>>> sv/bso_dp.sv
`timescale 1ns / 1ps
module bso_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  bso_pkg::cmd_type            cmd,
   output bso_pkg::status_type         status,
   input  logic [bso_pkg::DATA_W-1:0]  req_value,
   input  logic                        req_last_in,
   input  logic                        csr_valid,
   input  logic [bso_pkg::MODE_W-1:0]  csr_data,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [bso_pkg::DATA_W-1:0]  rsp_sorted_value,
   output logic                        rsp_last_out,
   output logic                        rsp_overflowed
);
   import bso_pkg::*;

   logic [DATA_W-1:0] store_mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              drop_ff, drop_in;
   logic [CNT_W-1:0]  pass_ff, pass_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [DATA_W-1:0] carry_ff, carry_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic              vld_ff, vld_in;
   logic [DATA_W-1:0] out_val_ff, out_val_in;
   logic              out_last_ff, out_last_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              swap;
   logic              div_start;
   logic              div_busy;
   logic [DATA_W-1:0] div_rem;
   logic [DATA_W-1:0] rd_mag;
   logic [CNT_W-1:0]  last_idx;

   bso_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (carry_ff),
      .divisor   (rd_mag),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   assign rd_mag    = rd_data_ff[DATA_W-1] ? (~rd_data_ff + 1'b1) : rd_data_ff;
   assign div_start = (cmd.op == OP_LATCH_B) && (mode_ff == MODE_REMAIN);
   assign last_idx  = count_ff - 1'b1;

   // compare of carried element a against following element b
   always_comb begin
      case (mode_ff)
         MODE_ASCEND:  swap = $signed(carry_ff) > $signed(b_ff);
         MODE_DESCEND: swap = $signed(b_ff) > $signed(carry_ff);
         MODE_REMAIN:  swap = (carry_ff != '0) && (b_ff != '0) &&
                              !carry_ff[DATA_W-1] && (div_rem != '0);
         default:      swap = 1'b0;
      endcase
   end

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      case (cmd.rd_sel)
         RD_ZERO: rd_addr = '0;
         RD_NEXT: rd_addr = j_ff + 1'b1;
         RD_EMIT: rd_addr = k_ff;
         default: rd_en   = 1'b0;
      endcase
   end

   always_comb begin
      mode_in     = csr_valid ? csr_data : mode_ff;
      count_in    = count_ff;
      drop_in     = drop_ff;
      pass_in     = pass_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      carry_in    = carry_ff;
      b_in        = b_ff;
      vld_in      = vld_ff && !rsp_ready;
      out_val_in  = out_val_ff;
      out_last_in = out_last_ff;
      out_ovf_in  = out_ovf_ff;
      wr_en       = 1'b0;
      wr_addr     = j_ff;
      wr_data     = carry_ff;
      case (cmd.op)
         OP_LOAD: begin
            if (count_ff < CNT_W'(CAPACITY)) begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IDX_W-1:0];
               wr_data  = req_value;
               count_in = count_ff + 1'b1;
            end else begin
               drop_in = 1'b1;
            end
            if (req_last_in) begin
               pass_in = '0;
            end
         end
         OP_CARRY: begin
            carry_in = rd_data_ff;
            j_in     = '0;
         end
         OP_LATCH_B: begin
            b_in = rd_data_ff;
         end
         OP_STEP: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff;
            wr_data  = swap ? b_ff : carry_ff;
            carry_in = swap ? carry_ff : b_ff;
            j_in     = j_ff + 1'b1;
         end
         OP_PASS_END: begin
            wr_en   = 1'b1;
            wr_addr = last_idx[IDX_W-1:0];
            wr_data = carry_ff;
            pass_in = pass_ff + 1'b1;
            k_in    = '0;
         end
         OP_EMIT_LOAD: begin
            vld_in      = 1'b1;
            out_val_in  = rd_data_ff;
            out_last_in = status.emit_last;
            out_ovf_in  = drop_ff;
         end
         OP_EMIT_NEXT: begin
            k_in = k_ff + 1'b1;
            if (status.emit_last) begin
               count_in = '0;
               drop_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ASCEND;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         vld_ff   <= vld_in;
      end
      pass_ff     <= pass_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      carry_ff    <= carry_in;
      b_ff        <= b_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   always_comb begin
      status.n_gt1     = count_ff > CNT_W'(1);
      status.pair_more = (CNT_W'(j_ff) + CNT_W'(2)) < count_ff;
      status.pass_last = (pass_ff + 1'b1) == count_ff;
      status.div_busy  = div_busy;
      status.emit_last = (CNT_W'(k_ff) + 1'b1) == count_ff;
      status.rsp_taken = vld_ff && rsp_ready;
   end

   assign rsp_valid        = vld_ff;
   assign rsp_sorted_value = out_val_ff;
   assign rsp_last_out     = out_last_ff;
   assign rsp_overflowed   = out_ovf_ff;

endmodule

>>> sv/bso_ctrl.sv
`timescale 1ns / 1ps
module bso_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_in,
   output logic                 req_ready,
   input  bso_pkg::status_type  status,
   output bso_pkg::cmd_type     cmd
);
   import bso_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_valid && req_last_in) begin
               state_in = S_PASS_START;
            end
         end
         S_PASS_START: state_in = S_PASS_CARRY;
         S_PASS_CARRY: state_in = status.n_gt1 ? S_READ : S_PASS_END;
         S_READ:       state_in = S_LATCH;
         S_LATCH:      state_in = S_DIV;
         S_DIV: begin
            if (!status.div_busy) begin
               state_in = S_STEP;
            end
         end
         S_STEP:       state_in = status.pair_more ? S_READ : S_PASS_END;
         S_PASS_END:   state_in = status.pass_last ? S_EMIT_RD : S_PASS_START;
         S_EMIT_RD:    state_in = S_EMIT_LD;
         S_EMIT_LD:    state_in = S_EMIT_WAIT;
         S_EMIT_WAIT: begin
            if (status.rsp_taken) begin
               state_in = status.emit_last ? S_LOAD : S_EMIT_RD;
            end
         end
         default:      state_in = S_LOAD;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.op     = OP_NONE;
      cmd.rd_sel = RD_NONE;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD;
            end
         end
         S_PASS_START: cmd.rd_sel = RD_ZERO;
         S_PASS_CARRY: cmd.op     = OP_CARRY;
         S_READ:       cmd.rd_sel = RD_NEXT;
         S_LATCH:      cmd.op     = OP_LATCH_B;
         S_STEP:       cmd.op     = OP_STEP;
         S_PASS_END:   cmd.op     = OP_PASS_END;
         S_EMIT_RD:    cmd.rd_sel = RD_EMIT;
         S_EMIT_LD:    cmd.op     = OP_EMIT_LOAD;
         S_EMIT_WAIT: begin
            if (status.rsp_taken) begin
               cmd.op = OP_EMIT_NEXT;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/bubble_sorter_with_order_modes.sv
`timescale 1ns / 1ps
// Bubble sorter with selectable order.
// req: one signed 32-bit element per transfer; last_in closes the set.
//   Up to 64 elements are kept; further elements are dropped and the set's
//   results carry overflowed = 1. A last_in on a dropped element still sorts.
// csr: 2-bit order mode (0 ascending, 1 descending, 2 remainder order),
//   always ready; write it only while no set is in progress.
// rsp: one transfer per held element in index order, last_out on the final one.
// Sequence: req is ready whenever the sorter loads. Once last_in arrives, the
//   block runs n passes of n-1 compare-swaps; each pass carries element 0, and
//   each pair reads the next element from the single-read-port memory, waits on
//   the bit-serial remainder unit in remainder mode and writes one back. Emission
//   holds each element in the output register until rsp takes it.
// Stalls: a result waits in the output register until rsp.ready; the sorter
//   does not accept a new set until the last result has been transferred.
// Reset: mode 0, empty set, no result pending; the element memory itself is
//   not cleared and needs no clearing pass.
module bubble_sorter_with_order_modes (
   input logic       clock,
   input logic       reset,
   bso_req_if.sink   req_chan,
   bso_rsp_if.source rsp_chan,
   bso_csr_if.sink   csr_chan
);
   import bso_pkg::*;

   cmd_type    cmd;
   status_type status;

   // config port never stalls
   assign csr_chan.ready = 1'b1;

   // sequencer: load, pass/pair loops, emit
   bso_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_last_in (req_chan.last_in),
      .req_ready   (req_chan.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // element memory, carry/compare logic, remainder unit, output register
   bso_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_chan.value),
      .req_last_in      (req_chan.last_in),
      .csr_valid        (csr_chan.valid),
      .csr_data         (csr_chan.data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_sorted_value (rsp_chan.sorted_value),
      .rsp_last_out     (rsp_chan.last_out),
      .rsp_overflowed   (rsp_chan.overflowed)
   );

endmodule
